### hw/rtl/wind_profile_interpolator_top_assert.svh
// Assertion macros for the wind profile interpolator checker.
`ifndef WIND_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH
`define WIND_PROFILE_INTERPOLATOR_TOP_ASSERT_SVH

// Clocked check, quiet while reset is asserted.
`define WPI_ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers reset itself.
`define WPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/wpi_pkg.sv
`default_nettype none
package wpi_pkg;

  localparam int ALT_W  = 24;
  localparam int WIND_W = 16;
  localparam int STAT_W = 3;
  localparam int FRAC_W = 16;
  localparam int DIV_W  = ALT_W + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd4;

  // Lower code wins on the result bus.
  localparam logic [1:0] PRIO_FIRST = 2'd0;
  localparam logic [1:0] PRIO_LAST  = 2'd1;
  localparam logic [1:0] PRIO_INNER = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_DIV,
    S_MUL_E,
    S_MUL_N
  } fsm_t;

  typedef struct packed {
    logic signed [ALT_W-1:0]  alt;
    logic signed [WIND_W-1:0] east;
    logic signed [WIND_W-1:0] north;
  } level_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] prio;
    logic       exact;
    level_t     lo;
    level_t     hi;
  } bus_t;

  typedef struct packed {
    logic                    ins_en;
    level_t                  new_lvl;
    logic signed [ALT_W-1:0] q_alt;
  } cell_ctl_t;

  typedef struct packed {
    logic occ;
    logic at_count;
    logic at_last;
    logic is_first;
  } cell_pos_t;

endpackage
`default_nettype wire

### hw/rtl/wpi_cell.sv
`default_nettype none
module wpi_cell (
  input  wire                  clk,
  input  wpi_pkg::cell_ctl_t   ctl,
  input  wpi_pkg::cell_pos_t   pos,
  input  wpi_pkg::level_t      prev_lvl,
  input  wire                  prev_gt,
  input  wire                  prev_le,
  input  wpi_pkg::bus_t        bus_in,
  output wpi_pkg::level_t      lvl,
  output logic                 gt,
  output logic                 le,
  output wpi_pkg::bus_t        bus_out
);

  wpi_pkg::level_t lvl_r, lvl_nxt;
  wpi_pkg::bus_t   bus_r, bus_nxt;
  wpi_pkg::bus_t   inj;
  logic            ge_last;

  assign gt      = pos.occ && ($signed(lvl_r.alt) > $signed(ctl.new_lvl.alt));
  assign le      = pos.occ && ($signed(ctl.q_alt) <= $signed(lvl_r.alt));
  assign ge_last = pos.at_last && ($signed(ctl.q_alt) >= $signed(lvl_r.alt));

  // Shift up behind the insertion point, drop the new level at it.
  always_comb begin
    lvl_nxt = lvl_r;
    if (ctl.ins_en) begin
      if (prev_gt) begin
        lvl_nxt = prev_lvl;
      end else if (gt || pos.at_count) begin
        lvl_nxt = ctl.new_lvl;
      end
    end
  end

  always_comb begin
    inj       = '0;
    inj.hi    = lvl_r;
    inj.lo    = prev_lvl;
    if (pos.is_first && le) begin
      inj.valid = 1'b1;
      inj.prio  = wpi_pkg::PRIO_FIRST;
      inj.exact = 1'b1;
    end else if (ge_last) begin
      inj.valid = 1'b1;
      inj.prio  = wpi_pkg::PRIO_LAST;
      inj.exact = 1'b1;
    end else if (le && !prev_le) begin
      inj.valid = 1'b1;
      inj.prio  = wpi_pkg::PRIO_INNER;
      inj.exact = 1'b0;
    end
  end

  always_comb begin
    bus_nxt = bus_in;
    if (inj.valid && (!bus_in.valid || inj.prio < bus_in.prio)) begin
      bus_nxt = inj;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r <= lvl_nxt;
    bus_r <= bus_nxt;
  end

  assign lvl     = lvl_r;
  assign bus_out = bus_r;

endmodule
`default_nettype wire

### hw/rtl/wpi_div.sv
`default_nettype none
module wpi_div (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire  [wpi_pkg::DIV_W-1:0]       num,
  input  wire  [wpi_pkg::DIV_W-1:0]       den,
  output logic                            done,
  output logic [wpi_pkg::FRAC_W-1:0]      quot
);

  localparam int CNT_W = $clog2(wpi_pkg::FRAC_W + 1);

  logic [wpi_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [wpi_pkg::DIV_W-1:0]  den_r;
  logic [wpi_pkg::FRAC_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       run_r, run_nxt, done_r, done_nxt;
  logic [wpi_pkg::DIV_W:0]    shl;
  logic [wpi_pkg::DIV_W:0]    diff;

  // One quotient bit per cycle, restoring.
  assign shl  = {rem_r, 1'b0};
  assign diff = shl - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      quot_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!diff[wpi_pkg::DIV_W]) begin
        rem_nxt  = diff[wpi_pkg::DIV_W-1:0];
        quot_nxt = {quot_r[wpi_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shl[wpi_pkg::DIV_W-1:0];
        quot_nxt = {quot_r[wpi_pkg::FRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(wpi_pkg::FRAC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

### hw/rtl/wind_profile_interpolator_top.sv
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+-----------------------------
// request   | in_req_type, in_altitude, in_level_east/north    | start high while busy low
// result    | out_east_wind, out_north_wind, out_status        | out_valid, one cycle each
//
// Insert, clear and an empty-table query: result registered in the cycle after the transaction.
// Query: the result bus sweeps down the level chain in S_SCAN, then the serial divider
//   (S_DIV) and the shared multiplier (S_MUL_E, S_MUL_N) run when the altitude lies
//   strictly between two levels.
// Request code 3 is taken and yields no result.
// Reset (rst_n low, synchronous) empties the table; stored levels are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module wind_profile_interpolator_top #(
  parameter int MAX_LEVELS = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         in_req_type,
  input  wire  signed [23:0] in_altitude,
  input  wire  signed [15:0] in_level_east,
  input  wire  signed [15:0] in_level_north,
  output logic               out_valid,
  output logic signed [15:0] out_east_wind,
  output logic signed [15:0] out_north_wind,
  output logic [2:0]         out_status
);

  localparam int CW = $clog2(MAX_LEVELS + 1);

  wpi_pkg::fsm_t      state_r, state_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      scan_cnt_r;
  logic signed [23:0] q_alt_r;
  wpi_pkg::bus_t      pick_r;
  logic [15:0]        t_r;
  logic signed [15:0] east_r;

  logic               out_valid_r;
  logic signed [15:0] out_east_r, out_north_r;
  logic [2:0]         out_status_r;

  wpi_pkg::cell_ctl_t ctl;
  wpi_pkg::level_t    lvl   [MAX_LEVELS];
  wpi_pkg::bus_t      bus   [MAX_LEVELS];
  logic               gt    [MAX_LEVELS];
  logic               le    [MAX_LEVELS];

  logic accept, full, scan_end, exact_hit, div_done;
  logic [15:0] quot;
  logic [wpi_pkg::DIV_W-1:0] div_num, div_den;

  assign accept   = start && !busy;
  assign full     = (count_r == CW'(MAX_LEVELS));
  // The head cell sees the query altitude from q_alt_r, registered at the transaction, so the
  // last cell's bus stage is complete only when scan_cnt_r reaches MAX_LEVELS.
  assign scan_end = (scan_cnt_r == CW'(MAX_LEVELS));

  // Level chain: each cell holds one sorted level and one stage of the result bus.
  assign ctl.ins_en  = accept && (in_req_type == wpi_pkg::REQ_INSERT) && !full;
  assign ctl.new_lvl = '{alt: in_altitude, east: in_level_east, north: in_level_north};
  assign ctl.q_alt   = q_alt_r;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    wpi_pkg::cell_pos_t pos;
    wpi_pkg::level_t    p_lvl;
    wpi_pkg::bus_t      p_bus;
    logic               p_gt, p_le;

    assign pos.occ      = (CW'(i) < count_r);
    assign pos.at_count = (CW'(i) == count_r);
    assign pos.at_last  = (CW'(i + 1) == count_r);
    assign pos.is_first = (i == 0);

    if (i == 0) begin : g_head
      assign p_lvl = '0;
      assign p_bus = '0;
      assign p_gt  = 1'b0;
      assign p_le  = 1'b0;
    end else begin : g_body
      assign p_lvl = lvl[i-1];
      assign p_bus = bus[i-1];
      assign p_gt  = gt[i-1];
      assign p_le  = le[i-1];
    end

    wpi_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos      (pos),
      .prev_lvl (p_lvl),
      .prev_gt  (p_gt),
      .prev_le  (p_le),
      .bus_in   (p_bus),
      .lvl      (lvl[i]),
      .gt       (gt[i]),
      .le       (le[i]),
      .bus_out  (bus[i])
    );
  end

  // Bracket picked off the chain's end; equal or collapsed segments take the upper level.
  assign exact_hit = pick_r.exact || (q_alt_r == pick_r.hi.alt) ||
                     ($signed(pick_r.hi.alt) <= $signed(pick_r.lo.alt));
  assign div_num   = {q_alt_r[23], q_alt_r} - {pick_r.lo.alt[23], pick_r.lo.alt};
  assign div_den   = {pick_r.hi.alt[23], pick_r.hi.alt} - {pick_r.lo.alt[23], pick_r.lo.alt};

  wpi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == wpi_pkg::S_PICK && !exact_hit),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // Shared lerp: c0 + round(t * (c1 - c0) / 65536), ties up, then saturate.
  logic signed [15:0] mc0, mc1;
  logic signed [16:0] mdiff;
  logic signed [33:0] mprod;
  logic signed [33:0] mround;
  logic signed [18:0] msum;
  logic signed [15:0] mres;

  always_comb begin
    if (state_r == wpi_pkg::S_MUL_E) begin
      mc0 = pick_r.lo.east;
      mc1 = pick_r.hi.east;
    end else begin
      mc0 = pick_r.lo.north;
      mc1 = pick_r.hi.north;
    end
    mdiff  = 17'(mc1) - 17'(mc0);
    mprod  = $signed({1'b0, t_r}) * mdiff;
    mround = mprod + 34'sd32768;
    msum   = 19'(mc0) + 19'($signed(mround[33:16]));
    if (msum > 19'sd32767) begin
      mres = 16'sh7fff;
    end else if (msum < -19'sd32768) begin
      mres = -16'sh8000;
    end else begin
      mres = msum[15:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wpi_pkg::S_IDLE: begin
        if (accept && in_req_type == wpi_pkg::REQ_QUERY && count_r != '0) begin
          state_nxt = wpi_pkg::S_SCAN;
        end
      end
      wpi_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = wpi_pkg::S_PICK;
        end
      end
      wpi_pkg::S_PICK:  state_nxt = exact_hit ? wpi_pkg::S_IDLE : wpi_pkg::S_DIV;
      wpi_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = wpi_pkg::S_MUL_E;
        end
      end
      wpi_pkg::S_MUL_E: state_nxt = wpi_pkg::S_MUL_N;
      wpi_pkg::S_MUL_N: state_nxt = wpi_pkg::S_IDLE;
      default:          state_nxt = wpi_pkg::S_IDLE;
    endcase
  end

  // Result strobe and fields for the coming cycle.
  logic               rv_nxt;
  logic signed [15:0] re_nxt, rn_nxt;
  logic [2:0]         rs_nxt;

  always_comb begin
    rv_nxt = 1'b0;
    re_nxt = '0;
    rn_nxt = '0;
    rs_nxt = wpi_pkg::ST_OK;
    unique case (state_r)
      wpi_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            wpi_pkg::REQ_INSERT: begin
              rv_nxt = 1'b1;
              rs_nxt = full ? wpi_pkg::ST_FULL : wpi_pkg::ST_STORED;
            end
            wpi_pkg::REQ_CLEAR: begin
              rv_nxt = 1'b1;
              rs_nxt = wpi_pkg::ST_CLEARED;
            end
            wpi_pkg::REQ_QUERY: begin
              rv_nxt = (count_r == '0);
              rs_nxt = wpi_pkg::ST_EMPTY;
            end
            default: rv_nxt = 1'b0;
          endcase
        end
      end
      wpi_pkg::S_PICK: begin
        rv_nxt = exact_hit;
        re_nxt = pick_r.hi.east;
        rn_nxt = pick_r.hi.north;
      end
      wpi_pkg::S_MUL_N: begin
        rv_nxt = 1'b1;
        re_nxt = east_r;
        rn_nxt = mres;
      end
      default: rv_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpi_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= rv_nxt;
      if (ctl.ins_en) begin
        count_r <= count_r + 1'b1;
      end else if (accept && in_req_type == wpi_pkg::REQ_CLEAR) begin
        count_r <= '0;
      end
    end
    out_east_r   <= re_nxt;
    out_north_r  <= rn_nxt;
    out_status_r <= rs_nxt;
    // Hold the query altitude; sweep the chain once.
    if (accept) begin
      q_alt_r    <= in_altitude;
      scan_cnt_r <= '0;
    end else if (state_r == wpi_pkg::S_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    if (state_r == wpi_pkg::S_SCAN && scan_end) begin
      pick_r <= bus[MAX_LEVELS-1];
    end
    if (div_done) begin
      t_r <= quot;
    end
    if (state_r == wpi_pkg::S_MUL_E) begin
      east_r <= mres;
    end
  end

  assign busy           = (state_r != wpi_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_east_wind  = out_east_r;
  assign out_north_wind = out_north_r;
  assign out_status     = out_status_r;

endmodule
`default_nettype wire

### hw/rtl/wpi_checker.sv
`default_nettype none
`include "wind_profile_interpolator_top_assert.svh"
module wpi_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire [1:0]  in_req_type,
  input wire [23:0] in_altitude,
  input wire [15:0] in_level_east,
  input wire [15:0] in_level_north,
  input wire        out_valid,
  input wire [15:0] out_east_wind,
  input wire [15:0] out_north_wind,
  input wire [2:0]  out_status
);

  logic unused_ok;
  assign unused_ok = ^{in_altitude, in_level_east, in_level_north};

  `WPI_ASSERT_SYNC(a_zero_wind, out_valid && out_status != wpi_pkg::ST_OK |-> out_east_wind == 16'd0 && out_north_wind == 16'd0, "wind not zero on non-query status")
  `WPI_ASSERT_SYNC(a_status_range, out_valid |-> out_status <= wpi_pkg::ST_CLEARED, "status code out of range")
  `WPI_ASSERT_SYNC(a_fast_result, start && !busy && (in_req_type == wpi_pkg::REQ_INSERT || in_req_type == wpi_pkg::REQ_CLEAR) |=> out_valid && !busy, "insert or clear result missing")
  `WPI_ASSERT_SYNC(a_query_moves, start && !busy && in_req_type == wpi_pkg::REQ_QUERY |=> busy || out_valid, "query dropped")
  `WPI_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

bind wind_profile_interpolator_top wpi_checker u_wpi_checker (.*);
`default_nettype wire
